// File: src/mnls_pkg.sv
// ----------------------------------------------------------------------------
// mnls_pkg
// Shared types and constants of the mono legato note stack: item structs,
// event codes, register indexes, sequencer states and reset values.
// ----------------------------------------------------------------------------
package mnls_pkg;

   localparam int STACK_DEPTH_DEF = 32;

   typedef enum logic [1:0] {
      FN_NOTE_ON  = 2'd0,
      FN_NOTE_OFF = 2'd1,
      FN_CTRL     = 2'd2,
      FN_BEND     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_CHANNEL_FILTER = 2'd0,
      CSR_SLOT1_CTRL     = 2'd1,
      CSR_SLOT2_CTRL     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SHIFT,
      ST_TOP,
      ST_DONE
   } state_type;

   localparam logic [6:0]  CC_ALL_NOTES_OFF = 7'd123;
   localparam logic [6:0]  CC_MOD_WHEEL     = 7'd1;
   localparam logic [6:0]  NOTE_RESET       = 7'd60;
   localparam logic [13:0] BEND_CENTRE      = 14'd8192;
   localparam logic [6:0]  SLOT1_RESET      = 7'd74;
   localparam logic [6:0]  SLOT2_RESET      = 7'd71;
   localparam logic [4:0]  FILTER_OMNI      = 5'd0;

   typedef struct packed {
      func_type    func;
      logic [4:0]  channel;
      logic [6:0]  key_number;
      logic [6:0]  data_value;
      logic [13:0] bend_value;
   } req_type;

   typedef struct packed {
      logic        gate;
      logic [6:0]  pitch_note;
      logic [6:0]  note_velocity;
      logic [5:0]  held_count;
      logic [6:0]  mod_wheel;
      logic [6:0]  slot1_value;
      logic [6:0]  slot2_value;
      logic [13:0] bend_position;
   } rsp_type;

endpackage

// File: src/mnls_stack_mem.sv
// ----------------------------------------------------------------------------
// mnls_stack_mem
// Key stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mnls_stack_mem
   import mnls_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int AW          = $clog2(STACK_DEPTH)
) (
   input  logic          clock,
   input  logic          mem_we,
   input  logic [AW-1:0] mem_waddr,
   input  logic [6:0]    mem_wdata,
   input  logic          mem_re,
   input  logic [AW-1:0] mem_raddr,
   output logic [6:0]    mem_rdata
);

   logic [6:0] mem_array [STACK_DEPTH];
   logic [6:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem_array[mem_raddr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// File: src/mnls_ctrl.sv
// ----------------------------------------------------------------------------
// mnls_ctrl
// Event sequencer: applies one item to the held-key state, compacting the
// key stack one entry per cycle through the stack memory.
// ----------------------------------------------------------------------------
module mnls_ctrl
   import mnls_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int AW          = $clog2(STACK_DEPTH),
   parameter int LW          = $clog2(STACK_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          pass,
   input  req_type       item,
   input  logic [6:0]    slot1_ctrl,
   input  logic [6:0]    slot2_ctrl,
   input  logic          load,
   output logic          busy,
   output logic          done,
   output rsp_type       snapshot,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output logic [6:0]    mem_wdata,
   output logic          mem_re,
   output logic [AW-1:0] mem_raddr,
   input  logic [6:0]    mem_rdata
);

   localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);
   localparam logic [LW-1:0] ONE_L   = LW'(1);

   state_type state_ff, state_in;

   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] wr_ptr_ff, wr_ptr_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          gate_ff, gate_in;
   logic [6:0]    note_ff, note_in;
   logic [6:0]    vel_ff, vel_in;
   logic [6:0]    mod_ff, mod_in;
   logic [6:0]    slot1_ff, slot1_in;
   logic [6:0]    slot2_ff, slot2_in;
   logic [13:0]   bend_ff, bend_in;
   logic [6:0]    key_ff, key_in;
   logic [6:0]    data_ff, data_in;
   logic          push_ff, push_in;

   logic walk_end;
   logic wr_full;
   logic is_note;

   assign walk_end = (rd_ptr_ff == len_ff) && !rd_pend_ff;
   assign wr_full  = (wr_ptr_ff == DEPTH_L);
   assign is_note  = (item.func == FN_NOTE_ON) || (item.func == FN_NOTE_OFF);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (pass && is_note) ? ST_WALK : ST_DONE;
            end
         end
         ST_WALK: begin
            if (walk_end) begin
               priority if (push_ff && wr_full) begin
                  state_in = ST_SHIFT;
               end else if (!push_ff && (wr_ptr_ff != '0)) begin
                  state_in = ST_TOP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHIFT: begin
            if (walk_end) begin
               state_in = ST_DONE;
            end
         end
         ST_TOP: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      len_in     = len_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_pend_in = 1'b0;
      gate_in    = gate_ff;
      note_in    = note_ff;
      vel_in     = vel_ff;
      mod_in     = mod_ff;
      slot1_in   = slot1_ff;
      slot2_in   = slot2_ff;
      bend_in    = bend_ff;
      key_in     = key_ff;
      data_in    = data_ff;
      push_in    = push_ff;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = key_ff;
      mem_re     = 1'b0;
      mem_raddr  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in    = item.key_number;
               data_in   = item.data_value;
               push_in   = (item.func == FN_NOTE_ON) && (item.data_value != '0);
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               if (pass) begin
                  unique case (item.func)
                     FN_CTRL: begin
                        if (item.key_number == CC_ALL_NOTES_OFF) begin
                           len_in  = '0;
                           gate_in = 1'b0;
                        end else begin
                           if (item.key_number == CC_MOD_WHEEL) begin
                              mod_in = item.data_value;
                           end
                           if (item.key_number == slot1_ctrl) begin
                              slot1_in = item.data_value;
                           end
                           if (item.key_number == slot2_ctrl) begin
                              slot2_in = item.data_value;
                           end
                        end
                     end
                     FN_BEND: begin
                        bend_in = item.bend_value;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_WALK, ST_SHIFT: begin
            if (rd_ptr_ff != len_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = rd_ptr_ff[AW-1:0];
               rd_ptr_in  = rd_ptr_ff + ONE_L;
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff && ((state_ff == ST_SHIFT) || (mem_rdata != key_ff))) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ptr_ff[AW-1:0];
               mem_wdata = mem_rdata;
               wr_ptr_in = wr_ptr_ff + ONE_L;
            end
            if (walk_end) begin
               if (push_ff) begin
                  if ((state_ff == ST_WALK) && wr_full) begin
                     // drop the oldest entry: copy 1..D-1 down by one
                     rd_ptr_in = ONE_L;
                     wr_ptr_in = '0;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = wr_ptr_ff[AW-1:0];
                     mem_wdata = key_ff;
                     len_in    = wr_ptr_ff + ONE_L;
                     note_in   = key_ff;
                     vel_in    = data_ff;
                     gate_in   = 1'b1;
                  end
               end else begin
                  len_in = wr_ptr_ff;
                  if (wr_ptr_ff != '0) begin
                     mem_re    = 1'b1;
                     mem_raddr = AW'(wr_ptr_ff - ONE_L);
                  end else begin
                     gate_in = 1'b0;
                  end
               end
            end
         end
         ST_TOP: begin
            note_in = mem_rdata;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         len_ff     <= '0;
         rd_pend_ff <= 1'b0;
         gate_ff    <= 1'b0;
         note_ff    <= NOTE_RESET;
         vel_ff     <= '0;
         mod_ff     <= '0;
         slot1_ff   <= '0;
         slot2_ff   <= '0;
         bend_ff    <= BEND_CENTRE;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         rd_pend_ff <= rd_pend_in;
         gate_ff    <= gate_in;
         note_ff    <= note_in;
         vel_ff     <= vel_in;
         mod_ff     <= mod_in;
         slot1_ff   <= slot1_in;
         slot2_ff   <= slot2_in;
         bend_ff    <= bend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      key_ff    <= key_in;
      data_ff   <= data_in;
      push_ff   <= push_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign done = (state_ff == ST_DONE);

   always_comb begin
      snapshot.gate          = gate_ff;
      snapshot.pitch_note    = note_ff;
      snapshot.note_velocity = vel_ff;
      snapshot.held_count    = 6'(len_ff);
      snapshot.mod_wheel     = mod_ff;
      snapshot.slot1_value   = slot1_ff;
      snapshot.slot2_value   = slot2_ff;
      snapshot.bend_position = bend_ff;
   end

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= DEPTH_L)
      else $error("stack length beyond depth");

   a_gate_tracks_len: assert property (@(posedge clock) disable iff (reset)
      gate_ff == (len_ff != '0))
      else $error("gate disagrees with held key count");

   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) || (state_ff == ST_SHIFT)) |-> (wr_ptr_ff <= rd_ptr_ff))
      else $error("compaction write pointer overtook read pointer");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write of the same stack entry in one cycle");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && !load) |=> (state_ff == ST_DONE))
      else $error("result dropped before hand-off");

endmodule

// File: src/midi_mono_legato_note_stack_top.sv
// ----------------------------------------------------------------------------
// midi_mono_legato_note_stack_top
// Mono legato MIDI receiver with last-note-priority key stack.
//
// Usage:
//   req_* carries one MIDI event item (note on, note off, control change,
//   pitch bend) and its channel. Every accepted item yields exactly one
//   rsp_* item: a snapshot of gate, pitch, velocity, held key count and
//   the latched controller and bend values after the event.
//   csr_* writes the channel filter (0 = omni) and the two slot controller
//   numbers; write them only while the block is idle.
//   Filtered, control change and bend items go straight to the result;
//   note items walk the stack, reading each held entry once, plus a
//   fetch of the new top after a release; for a new key pushed onto a
//   full stack, the stack is then copied down once more.
//   One item is in work at a time; req_stall is high while it runs. A
//   finished item waits in the output register, and the next item is
//   taken meanwhile. While rsp_stall is high the output holds and a
//   second finished item waits inside the sequencer.
//   Reset: the stack empties, pitch 60, bend 8192, all else 0; filter
//   omni, slots 74 and 71. No clearing pass is needed.
// ----------------------------------------------------------------------------
module midi_mono_legato_note_stack_top
   import mnls_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int LW = $clog2(STACK_DEPTH + 1);

   logic [4:0] filter_ff;
   logic [6:0] slot1_ctrl_ff;
   logic [6:0] slot2_ctrl_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;

   logic       busy;
   logic       done;
   logic       start;
   logic       pass;
   logic       load;
   rsp_type    snapshot;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [6:0]    mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [6:0]    mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff     <= FILTER_OMNI;
         slot1_ctrl_ff <= SLOT1_RESET;
         slot2_ctrl_ff <= SLOT2_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHANNEL_FILTER: filter_ff     <= csr_wdata[4:0];
            CSR_SLOT1_CTRL:     slot1_ctrl_ff <= csr_wdata;
            CSR_SLOT2_CTRL:     slot2_ctrl_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign pass      = (filter_ff == FILTER_OMNI) || (req_data.channel == filter_ff);
   assign load      = done && (!rsp_valid_ff || !rsp_stall);

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= snapshot;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mnls_ctrl #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW),
      .LW          (LW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .pass       (pass),
      .item       (req_data),
      .slot1_ctrl (slot1_ctrl_ff),
      .slot2_ctrl (slot2_ctrl_ff),
      .load       (load),
      .busy       (busy),
      .done       (done),
      .snapshot   (snapshot),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   mnls_stack_mem #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_stack_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule
